// ===== rtl/tcl_pkg.sv =====
package tcl_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DIST_W     = 32;
    localparam int CFG_W      = 32;

    // register indexes
    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_TOLERANCE   = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_CMP,
        S_MRD,
        S_MWR,
        S_ADV,
        S_CLR,
        S_CRD,
        S_CSZ,
        S_CWR,
        S_RI_RD,
        S_RI_CHK,
        S_RS_RD,
        S_RS_CMP,
        S_ORD,
        S_ORK,
        S_OSHOW
    } t_state;

    // request bundle into the component store
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
        logic             clear;
    } t_comp_req;

endpackage

// ===== rtl/tcl_comp_store.sv =====
module tcl_comp_store (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tcl_pkg::t_comp_req      i_req,
    output logic [tcl_pkg::IDX_W-1:0] o_rd_data
);
    import tcl_pkg::*;

    logic [IDX_W-1:0]      r_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_vld;
    logic [IDX_W-1:0]      r_rd_mem;
    logic [IDX_W-1:0]      r_rd_addr;
    logic                  r_rd_vld;

    // entry never written since clear reads as its own index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_req.rd_addr];
            if (i_req.clear) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_mem  <= r_mem[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
    end

    assign o_rd_data = r_rd_vld ? r_rd_mem : r_rd_addr;

endmodule

// ===== rtl/threshold_cluster_labeler.sv =====
// Channel   | valid       | stall        | payload
// ----------+-------------+--------------+------------------------------------------
// distance  | i_in_valid  | o_in_stall   | i_distance
// labels    | o_out_valid | i_out_stall  | o_point_index, o_cluster_label, o_last
// config    | i_cfg_we    | (none)       | i_cfg_index, i_cfg_data
//
// Flow: an unlinked pair goes straight from idle to S_ADV; a linked pair reads
//   both components, then sweeps every entry of the component store, read then
//   write per entry, unless both points already share a component.
// After the final pair: component sizes are counted and roots ranked, then each
//   label is offered in turn and held while the output is stalled.
// Reset: synchronous, active low; the component store reads as identity.
// o_in_stall is high whenever the sequencer is busy with an item or labels.
module threshold_cluster_labeler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [tcl_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [tcl_pkg::DIST_W-1:0]  i_distance,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tcl_pkg::IDX_W-1:0]   o_point_index,
    output logic [tcl_pkg::CNT_W-1:0]   o_cluster_label,
    output logic                        o_last
);
    import tcl_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_POINTS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_pc;
    logic [DIST_W-1:0] r_tol;

    // pair position and sequencer working registers
    logic [CNT_W-1:0] r_row, n_row, r_col, n_col;
    logic [IDX_W-1:0] r_la, n_la, r_keep, n_keep, r_drop, n_drop;
    logic [IDX_W-1:0] r_idx, n_idx, r_s, n_s, r_root, n_root, r_cnt, n_cnt;
    logic [CNT_W-1:0] r_szi, n_szi;

    logic [CNT_W-1:0] n_eff, n_m1;
    logic             in_xfer;
    logic             idx_at_end, s_at_end;

    // component store
    t_comp_req        comp_req;
    logic [IDX_W-1:0] comp_rd;

    // component size memory with per-entry valid (cleared before counting)
    logic [CNT_W-1:0]      r_sz_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_sz_vld;
    logic [CNT_W-1:0]      r_sz_rd;
    logic                  r_sz_rd_vld;
    logic [CNT_W-1:0]      sz_rd;
    logic [IDX_W-1:0]      sz_ra;
    logic                  sz_we, sz_clr;
    logic [IDX_W-1:0]      sz_wa;
    logic [CNT_W-1:0]      sz_wd;

    // rank memory (rank minus one), written for every root before use
    logic [IDX_W-1:0] r_rk_mem [MAX_POINTS];
    logic [IDX_W-1:0] r_rk_rd;
    logic             rk_re, rk_we;
    logic [IDX_W-1:0] rk_wd;

    logic             hit;
    logic [IDX_W-1:0] cnt_inc;
    logic [CNT_W-1:0] adv_col, adv_row;

    // clamp point count to 2..MAX_POINTS
    always_comb begin
        if (r_pc < CNT_W'(2)) begin
            n_eff = CNT_W'(2);
        end else if (r_pc > CNT_MAX) begin
            n_eff = CNT_MAX;
        end else begin
            n_eff = r_pc;
        end
    end
    assign n_m1 = n_eff - CNT_W'(1);

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign idx_at_end = ({1'b0, r_idx} == n_m1);
    assign s_at_end   = ({1'b0, r_s} == n_m1);
    assign sz_rd      = r_sz_rd_vld ? r_sz_rd : '0;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= CNT_MAX;
            r_tol <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POINT_COUNT: r_pc  <= i_cfg_data[CNT_W-1:0];
                REG_TOLERANCE:   r_tol <= i_cfg_data[DIST_W-1:0];
                default:         ;
            endcase
        end
    end

    tcl_comp_store u_comp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (comp_req),
        .o_rd_data (comp_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sz_vld    <= '0;
            r_sz_rd_vld <= 1'b0;
        end else begin
            r_sz_rd_vld <= r_sz_vld[sz_ra];
            if (sz_clr) begin
                r_sz_vld <= '0;
            end else if (sz_we) begin
                r_sz_vld[sz_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sz_we) begin
            r_sz_mem[sz_wa] <= sz_wd;
        end
        r_sz_rd <= r_sz_mem[sz_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            r_rk_mem[r_idx] <= rk_wd;
        end
        if (rk_re) begin
            r_rk_rd <= r_rk_mem[comp_rd];
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_la   <= n_la;
        r_keep <= n_keep;
        r_drop <= n_drop;
        r_idx  <= n_idx;
        r_s    <= n_s;
        r_root <= n_root;
        r_cnt  <= n_cnt;
        r_szi  <= n_szi;
    end

    // rank test: s is a root that outranks root idx
    assign hit = (comp_rd == r_s) && (r_s != r_idx) &&
                 ((sz_rd > r_szi) || ((sz_rd == r_szi) && (r_s < r_idx)));
    assign cnt_inc = r_cnt + IDX_W'(hit);
    assign adv_col = r_col + CNT_W'(1);
    assign adv_row = r_row + CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_la     = r_la;
        n_keep   = r_keep;
        n_drop   = r_drop;
        n_idx    = r_idx;
        n_s      = r_s;
        n_root   = r_root;
        n_cnt    = r_cnt;
        n_szi    = r_szi;
        comp_req = '{rd_addr: r_idx, wr_en: 1'b0, wr_addr: r_idx,
                     wr_data: r_keep, clear: 1'b0};
        sz_ra    = r_idx;
        sz_we    = 1'b0;
        sz_clr   = 1'b0;
        sz_wa    = r_root;
        sz_wd    = sz_rd + CNT_W'(1);
        rk_re    = 1'b0;
        rk_we    = 1'b0;
        rk_wd    = cnt_inc;
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (r_row >= n_m1 || r_col >= n_eff) begin
                        n_state = S_CLR;
                    end else if (i_distance < r_tol) begin
                        n_state = S_RDA;
                    end else begin
                        n_state = S_ADV;
                    end
                end
            end
            S_RDA: begin
                comp_req.rd_addr = r_row[IDX_W-1:0];
                n_state = S_RDB;
            end
            S_RDB: begin
                comp_req.rd_addr = r_col[IDX_W-1:0];
                n_la    = comp_rd;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_la == comp_rd) begin
                    n_state = S_ADV;
                end else begin
                    n_keep  = (r_la < comp_rd) ? r_la : comp_rd;
                    n_drop  = (r_la < comp_rd) ? comp_rd : r_la;
                    n_idx   = '0;
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                comp_req.wr_en = (comp_rd == r_drop);
                if (r_idx == IDX_LAST) begin
                    n_state = S_ADV;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_MRD;
                end
            end
            S_ADV: begin
                if (adv_col >= n_eff) begin
                    if (adv_row >= n_m1) begin
                        n_state = S_CLR;
                    end else begin
                        n_row   = adv_row;
                        n_col   = adv_row + CNT_W'(1);
                        n_state = S_IDLE;
                    end
                end else begin
                    n_col   = adv_col;
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                sz_clr  = 1'b1;
                n_idx   = '0;
                n_state = S_CRD;
            end
            S_CRD: begin
                n_state = S_CSZ;
            end
            S_CSZ: begin
                sz_ra   = comp_rd;
                n_root  = comp_rd;
                n_state = S_CWR;
            end
            S_CWR: begin
                sz_we = 1'b1;
                if (idx_at_end) begin
                    n_idx   = '0;
                    n_state = S_RI_RD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_CRD;
                end
            end
            S_RI_RD: begin
                n_state = S_RI_CHK;
            end
            S_RI_CHK: begin
                if (comp_rd == r_idx) begin
                    n_szi   = sz_rd;
                    n_cnt   = '0;
                    n_s     = '0;
                    n_state = S_RS_RD;
                end else if (idx_at_end) begin
                    n_idx   = '0;
                    n_state = S_ORD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RI_RD;
                end
            end
            S_RS_RD: begin
                comp_req.rd_addr = r_s;
                sz_ra   = r_s;
                n_state = S_RS_CMP;
            end
            S_RS_CMP: begin
                n_cnt = cnt_inc;
                if (s_at_end) begin
                    rk_we = 1'b1;
                    if (idx_at_end) begin
                        n_idx   = '0;
                        n_state = S_ORD;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RI_RD;
                    end
                end else begin
                    n_s     = r_s + IDX_W'(1);
                    n_state = S_RS_RD;
                end
            end
            S_ORD: begin
                n_state = S_ORK;
            end
            S_ORK: begin
                rk_re   = 1'b1;
                n_state = S_OSHOW;
            end
            S_OSHOW: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (idx_at_end) begin
                        // matrix done: back to identity components
                        comp_req.clear = 1'b1;
                        n_row   = '0;
                        n_col   = CNT_W'(1);
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_point_index   = r_idx;
    assign o_cluster_label = {1'b0, r_rk_rd} + CNT_W'(1);
    assign o_last          = idx_at_end;

    // no label may be offered while a distance is taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> !o_out_valid)
        else $error("distance accepted during label output");

    // pair position stays in the upper triangle between items
    a_upper_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_col > r_row))
        else $error("column not above row");

    // last flag only on the final point
    a_last_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> ({1'b0, o_point_index} == n_m1))
        else $error("last flag on wrong point");

    // after the final label, the pair counters restart
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=>
            (r_row == '0 && r_col == CNT_W'(1) && r_state == S_IDLE))
        else $error("pair counters not restarted");

endmodule
